// File: rtl/stoi_pkg.sv
// shared types, constants and helper functions for the string-to-integer unit
// no dependencies
`default_nettype none

package stoi_pkg;

   // defaults for top-level parameters
   localparam int MAX_SYMBOLS_DEFAULT = 16;
   localparam int VALUE_BITS_DEFAULT  = 32;

   // fixed field widths
   localparam int CHAR_BITS   = 8;
   localparam int WORD_BITS   = 64;
   localparam int SIZE_BITS   = 5;
   localparam int DIGIT_BITS  = 4;
   localparam int RADIX_BITS  = 5;
   localparam int OUT_BITS    = 32;
   localparam int INDEX_BITS  = 2;

   // queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int PTR_BITS    = $clog2(QUEUE_DEPTH);
   localparam int COUNT_BITS  = $clog2(QUEUE_DEPTH + 1);

   // character codes
   localparam logic [CHAR_BITS-1:0] CH_PLUS    = 8'd43;
   localparam logic [CHAR_BITS-1:0] CH_MINUS   = 8'd45;
   localparam logic [CHAR_BITS-1:0] CH_SPACE   = 8'd32;
   localparam logic [CHAR_BITS-1:0] CH_TAB     = 8'd9;
   localparam logic [CHAR_BITS-1:0] CH_CR      = 8'd13;

   // register indexes
   localparam logic [INDEX_BITS-1:0] REG_ALPHA_LOW  = 2'd0;
   localparam logic [INDEX_BITS-1:0] REG_ALPHA_HIGH = 2'd1;
   localparam logic [INDEX_BITS-1:0] REG_ALPHA_SIZE = 2'd2;

   // parse phases
   typedef enum logic [1:0] {
      PH_SPACE = 2'd0,
      PH_SIGN  = 2'd1,
      PH_DIGIT = 2'd2,
      PH_DONE  = 2'd3
   } phase_type;

   // configuration as seen by the front
   typedef struct packed {
      logic [WORD_BITS-1:0]  alpha_low;
      logic [WORD_BITS-1:0]  alpha_high;
      logic [RADIX_BITS-1:0] radix;
   } cfg_type;

   // one classified character
   typedef struct packed {
      logic                  is_space;
      logic                  is_sign;
      logic                  is_minus;
      logic                  digit_hit;
      logic [DIGIT_BITS-1:0] digit;
      logic [RADIX_BITS-1:0] radix;
      logic                  last;
      logic                  bad;
   } item_type;

   // symbol k of the alphabet
   function automatic logic [CHAR_BITS-1:0] symbol_at(
      input logic [WORD_BITS-1:0]  low,
      input logic [WORD_BITS-1:0]  high,
      input logic [DIGIT_BITS-1:0] k
   );
      logic [WORD_BITS-1:0] w;
      w = k[DIGIT_BITS-1] ? high : low;
      return w[{k[DIGIT_BITS-2:0], 3'b000} +: CHAR_BITS];
   endfunction

   function automatic logic is_space_char(input logic [CHAR_BITS-1:0] c);
      return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
   endfunction

   function automatic logic is_sign_char(input logic [CHAR_BITS-1:0] c);
      return (c == CH_PLUS) || (c == CH_MINUS);
   endfunction

endpackage

`default_nettype wire

// File: rtl/string_to_int_any_base_unit.sv
// string to signed integer in a configurable radix: one character per beat.
// a result goes through the queue slot and the result register to the rsp_ ports.
// throughput: one character per cycle unless full, set by the back's single multiply-add.
// the front classifies on entry; a 4-entry queue decouples it from the back.
// reset: synchronous, clears alphabet registers, parse state, queue and result.
// top level; depends on stoi_pkg, stoi_csr, stoi_front, stoi_queue, stoi_back
`default_nettype none

module string_to_int_any_base_unit #(
   parameter int MAX_SYMBOLS = stoi_pkg::MAX_SYMBOLS_DEFAULT,
   parameter int VALUE_BITS  = stoi_pkg::VALUE_BITS_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // character beats
   input  wire logic                              push,
   output logic                                   full,
   input  wire logic [stoi_pkg::CHAR_BITS-1:0]    req_char_code,
   input  wire logic                              req_end_of_text,
   // result beats
   output logic                                   empty,
   input  wire logic                              pop,
   output logic signed [stoi_pkg::OUT_BITS-1:0]   rsp_value,
   output logic                                   rsp_alphabet_error,
   // configuration
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [stoi_pkg::INDEX_BITS-1:0]   csr_index,
   input  wire logic [stoi_pkg::WORD_BITS-1:0]    csr_wdata
);

   stoi_pkg::cfg_type                 cfg;
   stoi_pkg::item_type                front_item;
   stoi_pkg::item_type                back_item;
   logic                              q_empty;
   logic                              q_pop;
   logic [stoi_pkg::COUNT_BITS-1:0]   q_count;

   stoi_csr #(.MAX_SYMBOLS(MAX_SYMBOLS)) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   stoi_front #(.MAX_SYMBOLS(MAX_SYMBOLS)) u_front (
      .cfg         (cfg),
      .char_code   (req_char_code),
      .end_of_text (req_end_of_text),
      .item        (front_item)
   );

   stoi_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (front_item),
      .full      (full),
      .pop       (q_pop),
      .pop_item  (back_item),
      .empty     (q_empty),
      .count     (q_count)
   );

   stoi_back #(.VALUE_BITS(VALUE_BITS)) u_back (
      .clock              (clock),
      .reset              (reset),
      .item               (back_item),
      .item_empty         (q_empty),
      .item_pop           (q_pop),
      .rsp_empty          (empty),
      .rsp_pop            (pop),
      .rsp_value          (rsp_value),
      .rsp_alphabet_error (rsp_alphabet_error)
   );

`ifndef ASSERT_OFF
   // a bad alphabet always reports zero
   a_bad_gives_zero: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_alphabet_error) |-> (rsp_value == '0))
      else $error("alphabet error with nonzero value");

   // reset leaves no result and an open input
   a_reset_clears: assert property (@(posedge clock)
      reset |=> (empty && !full))
      else $error("result or full flag after reset");

   // queue fill never passes its depth, and full tracks it
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      (q_count <= stoi_pkg::COUNT_BITS'(stoi_pkg::QUEUE_DEPTH)) &&
      (full == (q_count == stoi_pkg::COUNT_BITS'(stoi_pkg::QUEUE_DEPTH))))
      else $error("queue fill count out of range");
`endif

endmodule

`default_nettype wire

// File: rtl/stoi_csr.sv
// configuration registers: alphabet words and size, radix clamp
// depends on stoi_pkg
`default_nettype none

module stoi_csr #(
   parameter int MAX_SYMBOLS = stoi_pkg::MAX_SYMBOLS_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [stoi_pkg::INDEX_BITS-1:0]   csr_index,
   input  wire logic [stoi_pkg::WORD_BITS-1:0]    csr_wdata,
   output stoi_pkg::cfg_type                      cfg
);

   logic [stoi_pkg::WORD_BITS-1:0] low_ff, low_in;
   logic [stoi_pkg::WORD_BITS-1:0] high_ff, high_in;
   logic [stoi_pkg::SIZE_BITS-1:0] size_ff, size_in;
   logic                           wr;

   assign csr_ready = 1'b1;
   assign wr        = csr_valid & csr_ready;

   // register write decode
   always_comb begin
      low_in  = low_ff;
      high_in = high_ff;
      size_in = size_ff;
      if (wr) begin
         case (csr_index)
            stoi_pkg::REG_ALPHA_LOW:  low_in  = csr_wdata;
            stoi_pkg::REG_ALPHA_HIGH: high_in = csr_wdata;
            stoi_pkg::REG_ALPHA_SIZE: size_in = csr_wdata[stoi_pkg::SIZE_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff  <= '0;
         high_ff <= '0;
         size_ff <= '0;
      end else begin
         low_ff  <= low_in;
         high_ff <= high_in;
         size_ff <= size_in;
      end
   end

   // radix is the size clamped to the symbol count
   always_comb begin
      cfg.alpha_low  = low_ff;
      cfg.alpha_high = high_ff;
      if (size_ff > stoi_pkg::RADIX_BITS'(MAX_SYMBOLS))
         cfg.radix = stoi_pkg::RADIX_BITS'(MAX_SYMBOLS);
      else
         cfg.radix = size_ff;
   end

endmodule

`default_nettype wire

// File: rtl/stoi_front.sv
// front: classifies each character (space, sign, digit lookup) and checks the alphabet
// depends on stoi_pkg
`default_nettype none

module stoi_front #(
   parameter int MAX_SYMBOLS = stoi_pkg::MAX_SYMBOLS_DEFAULT
) (
   input  wire stoi_pkg::cfg_type                 cfg,
   input  wire logic [stoi_pkg::CHAR_BITS-1:0]    char_code,
   input  wire logic                              end_of_text,
   output stoi_pkg::item_type                     item
);

   logic [stoi_pkg::CHAR_BITS-1:0] sym [MAX_SYMBOLS];
   logic [MAX_SYMBOLS-1:0]         in_use;
   logic [MAX_SYMBOLS-1:0]         hit;
   logic                           bad;
   logic                           found;
   logic [stoi_pkg::DIGIT_BITS-1:0] digit;

   // symbols and which of them are in use
   always_comb begin
      for (int k = 0; k < MAX_SYMBOLS; k++) begin
         sym[k]    = stoi_pkg::symbol_at(cfg.alpha_low, cfg.alpha_high,
                                         stoi_pkg::DIGIT_BITS'(k));
         in_use[k] = stoi_pkg::RADIX_BITS'(k) < cfg.radix;
         hit[k]    = in_use[k] && (sym[k] == char_code);
      end
   end

   // lowest matching position wins
   always_comb begin
      found = 1'b0;
      digit = '0;
      for (int k = MAX_SYMBOLS - 1; k >= 0; k--) begin
         if (hit[k]) begin
            found = 1'b1;
            digit = stoi_pkg::DIGIT_BITS'(k);
         end
      end
   end

   // alphabet check: signs, whitespace or duplicates among used symbols
   always_comb begin
      bad = 1'b0;
      for (int i = 0; i < MAX_SYMBOLS; i++) begin
         if (in_use[i] && (stoi_pkg::is_sign_char(sym[i]) ||
                           stoi_pkg::is_space_char(sym[i])))
            bad = 1'b1;
         for (int j = i + 1; j < MAX_SYMBOLS; j++) begin
            if (in_use[i] && in_use[j] && (sym[i] == sym[j]))
               bad = 1'b1;
         end
      end
   end

   always_comb begin
      item.is_space  = stoi_pkg::is_space_char(char_code);
      item.is_sign   = stoi_pkg::is_sign_char(char_code);
      item.is_minus  = (char_code == stoi_pkg::CH_MINUS);
      item.digit_hit = found;
      item.digit     = digit;
      item.radix     = cfg.radix;
      item.last      = end_of_text;
      item.bad       = bad;
   end

endmodule

`default_nettype wire

// File: rtl/stoi_queue.sv
// short queue of classified characters between front and back
// depends on stoi_pkg
`default_nettype none

module stoi_queue (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               push,
   input  wire stoi_pkg::item_type                 push_item,
   output logic                                    full,
   input  wire logic                               pop,
   output stoi_pkg::item_type                      pop_item,
   output logic                                    empty,
   output logic [stoi_pkg::COUNT_BITS-1:0]         count
);

   stoi_pkg::item_type                 slot_ff [stoi_pkg::QUEUE_DEPTH];
   logic [stoi_pkg::PTR_BITS-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [stoi_pkg::PTR_BITS-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [stoi_pkg::COUNT_BITS-1:0]    count_ff, count_in;
   logic                               do_push, do_pop;

   assign full     = (count_ff == stoi_pkg::COUNT_BITS'(stoi_pkg::QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign count    = count_ff;
   assign do_push  = push & ~full;
   assign do_pop   = pop & ~empty;
   assign pop_item = slot_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop)
         count_in = count_ff + 1'b1;
      else if (do_pop && !do_push)
         count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push)
         slot_ff[wr_ptr_ff] <= push_item;
   end

endmodule

`default_nettype wire

// File: rtl/stoi_back.sv
// back: parse state machine, multiply-accumulate and result register
// depends on stoi_pkg
`default_nettype none

module stoi_back #(
   parameter int VALUE_BITS = stoi_pkg::VALUE_BITS_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire stoi_pkg::item_type                item,
   input  wire logic                              item_empty,
   output logic                                   item_pop,
   output logic                                   rsp_empty,
   input  wire logic                              rsp_pop,
   output logic signed [stoi_pkg::OUT_BITS-1:0]   rsp_value,
   output logic                                   rsp_alphabet_error
);

   localparam int EXT_BITS = 64;

   stoi_pkg::phase_type      phase_ff, phase_in;
   logic                     neg_ff, neg_in;
   logic [VALUE_BITS-1:0]    acc_ff, acc_in;
   logic [VALUE_BITS-1:0]    mul_w;
   logic                     out_valid_ff, out_valid_in;
   logic [VALUE_BITS-1:0]    out_acc_ff;
   logic                     out_neg_ff;
   logic                     out_bad_ff;
   logic                     take;
   logic [VALUE_BITS-1:0]    signed_v;
   logic [EXT_BITS-1:0]      ext_v;

   // an item moves on unless it would produce a result that has nowhere to go
   assign take     = ~item_empty & (~item.last | ~out_valid_ff | rsp_pop);
   assign item_pop = take;
   assign mul_w    = acc_ff * VALUE_BITS'(item.radix);

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (take) begin
         if (phase_ff != stoi_pkg::PH_DONE) begin
            if (phase_ff == stoi_pkg::PH_SPACE && item.is_space)
               phase_in = stoi_pkg::PH_SPACE;
            else if (phase_ff != stoi_pkg::PH_DIGIT && item.is_sign)
               phase_in = stoi_pkg::PH_SIGN;
            else if (item.digit_hit)
               phase_in = stoi_pkg::PH_DIGIT;
            else
               phase_in = stoi_pkg::PH_DONE;
         end
         if (item.last)
            phase_in = stoi_pkg::PH_SPACE;
      end
   end

   // accumulator and sign
   always_comb begin
      acc_in = acc_ff;
      neg_in = neg_ff;
      if (take && phase_ff != stoi_pkg::PH_DONE) begin
         if (phase_ff == stoi_pkg::PH_SPACE && item.is_space) begin
            acc_in = acc_ff;
         end else if (phase_ff != stoi_pkg::PH_DIGIT && item.is_sign) begin
            neg_in = neg_ff ^ item.is_minus;
         end else if (item.digit_hit) begin
            acc_in = mul_w + VALUE_BITS'(item.digit);
         end
      end
      if (take && item.last) begin
         acc_in = '0;
         neg_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= stoi_pkg::PH_SPACE;
         neg_ff   <= 1'b0;
         acc_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         neg_ff   <= neg_in;
         acc_ff   <= acc_in;
      end
   end

   // result register
   always_comb begin
      out_valid_in = out_valid_ff;
      if (take && item.last)
         out_valid_in = 1'b1;
      else if (rsp_pop)
         out_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset)
         out_valid_ff <= 1'b0;
      else
         out_valid_ff <= out_valid_in;
   end

   // result payload: final accumulator value, sign and alphabet flag of the text just ended
   always_ff @(posedge clock) begin
      if (take && item.last) begin
         out_acc_ff <= (phase_ff != stoi_pkg::PH_DONE) ? acc_in_pre() : acc_ff;
         out_neg_ff <= neg_pre();
         out_bad_ff <= item.bad;
      end
   end

   // value after this item, before the end-of-text clear
   function automatic logic [VALUE_BITS-1:0] acc_in_pre();
      logic [VALUE_BITS-1:0] a;
      a = acc_ff;
      if (!(phase_ff == stoi_pkg::PH_SPACE && item.is_space) &&
          !(phase_ff != stoi_pkg::PH_DIGIT && item.is_sign) && item.digit_hit)
         a = mul_w + VALUE_BITS'(item.digit);
      return a;
   endfunction

   function automatic logic neg_pre();
      logic n;
      n = neg_ff;
      if (phase_ff != stoi_pkg::PH_DONE &&
          !(phase_ff == stoi_pkg::PH_SPACE && item.is_space) &&
          phase_ff != stoi_pkg::PH_DIGIT && item.is_sign)
         n = neg_ff ^ item.is_minus;
      return n;
   endfunction

   // negate, sign-extend and fit to the result width
   always_comb begin
      signed_v = out_neg_ff ? (~out_acc_ff + 1'b1) : out_acc_ff;
      for (int i = 0; i < EXT_BITS; i++) begin
         if (i < VALUE_BITS)
            ext_v[i] = signed_v[i];
         else
            ext_v[i] = signed_v[VALUE_BITS-1];
      end
   end

   assign rsp_empty          = ~out_valid_ff;
   assign rsp_value          = out_bad_ff ? '0 : ext_v[stoi_pkg::OUT_BITS-1:0];
   assign rsp_alphabet_error = out_bad_ff;

endmodule

`default_nettype wire
